/* hdl/mmh_pkg.sv */
// shared types, constants and codes for the multilane mix64 hash
package mmh_pkg;

  localparam int MAX_LANES = 4;
  localparam int MODE_W = 3;

  localparam logic [63:0] MIX_K1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_K2 = 64'h94d049bb133111eb;

  localparam logic [1:0] REQ_WORD = 2'd0;
  localparam logic [1:0] REQ_TAIL = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;
  localparam logic [1:0] REQ_RSV = 2'd3;

  localparam logic [MODE_W-1:0] MODE_16 = 3'd0;
  localparam logic [MODE_W-1:0] MODE_32 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_64 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_128 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_256 = 3'd4;

  typedef struct packed {
    logic [1:0] req_type;
    logic [63:0] data_word;
  } mmh_in_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic last_word;
  } mmh_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_PREP,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic second;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic emit_busy;
  } dp_stat_t;

endpackage

/* hdl/mmh_ctrl.sv */
// sequencer for the round steps, finish and digest hand-off
module mmh_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [1:0] in_type,
  input  mmh_pkg::dp_stat_t stat,
  output logic in_stall,
  output mmh_pkg::dp_cmd_t cmd
);

  mmh_pkg::state_t state, state_next;
  logic second;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmh_pkg::ST_IDLE;
      second <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mmh_pkg::ST_PREP) begin
        second <= 1'b0;
      end else if (state == mmh_pkg::ST_MUL2) begin
        second <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mmh_pkg::ST_IDLE: begin
        if (in_valid && (in_type != mmh_pkg::REQ_RSV)) state_next = mmh_pkg::ST_PREP;
      end
      mmh_pkg::ST_PREP: state_next = mmh_pkg::ST_MUL0;
      mmh_pkg::ST_MUL0: state_next = mmh_pkg::ST_MUL1;
      mmh_pkg::ST_MUL1: state_next = mmh_pkg::ST_MUL2;
      mmh_pkg::ST_MUL2: begin
        if (!second) state_next = mmh_pkg::ST_MUL0;
        else if (stat.req_type == mmh_pkg::REQ_FINISH) state_next = mmh_pkg::ST_FIN;
        else state_next = mmh_pkg::ST_IDLE;
      end
      mmh_pkg::ST_FIN: begin
        if (!stat.emit_busy) state_next = mmh_pkg::ST_IDLE;
      end
      default: state_next = mmh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != mmh_pkg::ST_IDLE);
    cmd.second = second;
    unique case (state)
      mmh_pkg::ST_IDLE: cmd.op = in_valid ? mmh_pkg::OP_CAPTURE : mmh_pkg::OP_NONE;
      mmh_pkg::ST_PREP: cmd.op = mmh_pkg::OP_PREP;
      mmh_pkg::ST_MUL0: cmd.op = mmh_pkg::OP_MUL0;
      mmh_pkg::ST_MUL1: cmd.op = mmh_pkg::OP_MUL1;
      mmh_pkg::ST_MUL2: cmd.op = mmh_pkg::OP_MUL2;
      mmh_pkg::ST_FIN: cmd.op = stat.emit_busy ? mmh_pkg::OP_NONE : mmh_pkg::OP_EMIT;
      default: cmd.op = mmh_pkg::OP_NONE;
    endcase
  end

endmodule

/* hdl/mmh_datapath.sv */
// lane registers, per-lane multiply unit, byte counter and digest buffer
module mmh_datapath #(
  parameter int MAX_LANES = mmh_pkg::MAX_LANES
) (
  input  logic clk,
  input  logic rst,
  input  mmh_pkg::dp_cmd_t cmd,
  output mmh_pkg::dp_stat_t stat,
  input  mmh_pkg::mmh_in_t in_data,
  input  logic cfg_valid,
  input  logic [mmh_pkg::MODE_W-1:0] cfg_data,
  output logic out_valid,
  input  logic out_stall,
  output mmh_pkg::mmh_out_t out_data
);

  localparam int IDX_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int REM_W = $clog2(MAX_LANES + 1);

  logic [1:0] item_type;
  logic [63:0] item_data;
  logic [63:0] byte_count;
  logic tail_phase;
  logic [mmh_pkg::MODE_W-1:0] digest_mode;
  logic [REM_W-1:0] rem;
  logic [63:0] lane [MAX_LANES];
  logic [63:0] x [MAX_LANES];
  logic [63:0] acc [MAX_LANES];
  logic [63:0] digest_buf [MAX_LANES];

  logic [63:0] value;
  logic inv;
  logic [2:0] mode_lanes;
  logic [REM_W-1:0] n_lanes;
  logic [63:0] mask;
  logic [REM_W-1:0] rem_m1;
  logic [IDX_W-1:0] ridx;

  always_comb begin
    unique case (item_type)
      mmh_pkg::REQ_WORD: value = item_data;
      mmh_pkg::REQ_TAIL: value = {56'd0, item_data[7:0]};
      default: value = byte_count;
    endcase
    inv = ((item_type == mmh_pkg::REQ_TAIL) && !tail_phase)
        || ((item_type == mmh_pkg::REQ_FINISH) && tail_phase);
  end

  always_comb begin
    mask = '1;
    unique case (digest_mode)
      mmh_pkg::MODE_16: begin
        mode_lanes = 3'd1;
        mask = 64'h0000_0000_0000_ffff;
      end
      mmh_pkg::MODE_32: begin
        mode_lanes = 3'd1;
        mask = 64'h0000_0000_ffff_ffff;
      end
      mmh_pkg::MODE_128: mode_lanes = 3'd2;
      mmh_pkg::MODE_256: mode_lanes = 3'd4;
      default: mode_lanes = 3'd1;
    endcase
    if (int'(mode_lanes) > MAX_LANES) n_lanes = REM_W'(MAX_LANES);
    else n_lanes = REM_W'(mode_lanes);
  end

  for (genvar i = 0; i < MAX_LANES; i++) begin : g_lane
    logic [63:0] base, t, k, s, prod;
    logic [31:0] ma, mb;

    always_comb begin
      base = inv ? ~lane[i] : lane[i];
      t = (base ^ value) - 64'(i + 1);
      k = cmd.second ? mmh_pkg::MIX_K2 : mmh_pkg::MIX_K1;
      ma = (cmd.op == mmh_pkg::OP_MUL2) ? x[i][63:32] : x[i][31:0];
      mb = (cmd.op == mmh_pkg::OP_MUL1) ? k[63:32] : k[31:0];
      prod = {32'd0, ma} * {32'd0, mb};
      s = acc[i] + {prod[31:0], 32'd0};
    end

    always_ff @(posedge clk) begin
      unique case (cmd.op)
        mmh_pkg::OP_PREP: x[i] <= t ^ (t >> 30);
        mmh_pkg::OP_MUL0: acc[i] <= prod;
        mmh_pkg::OP_MUL1: acc[i] <= s;
        mmh_pkg::OP_MUL2: begin
          if (!cmd.second) x[i] <= s ^ (s >> 27);
        end
        mmh_pkg::OP_EMIT: digest_buf[i] <= lane[i] & mask;
        default: ;
      endcase
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        lane[i] <= '0;
      end else if ((cmd.op == mmh_pkg::OP_MUL2) && cmd.second) begin
        lane[i] <= s ^ (s >> 31);
      end else if (cmd.op == mmh_pkg::OP_EMIT) begin
        lane[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == mmh_pkg::OP_CAPTURE) begin
      item_type <= in_data.req_type;
      item_data <= in_data.data_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      tail_phase <= 1'b0;
      digest_mode <= mmh_pkg::MODE_64;
      rem <= '0;
    end else begin
      if (cfg_valid) digest_mode <= cfg_data;
      if ((cmd.op == mmh_pkg::OP_MUL2) && cmd.second) begin
        if (item_type == mmh_pkg::REQ_WORD) begin
          byte_count <= byte_count + 64'd8;
        end else if (item_type == mmh_pkg::REQ_TAIL) begin
          byte_count <= byte_count + 64'd1;
          tail_phase <= 1'b1;
        end
      end
      if (cmd.op == mmh_pkg::OP_EMIT) begin
        byte_count <= '0;
        tail_phase <= 1'b0;
        rem <= n_lanes;
      end else if (out_valid && !out_stall) begin
        rem <= rem - REM_W'(1);
      end
    end
  end

  always_comb begin
    rem_m1 = rem - REM_W'(1);
    ridx = rem_m1[IDX_W-1:0];
    out_valid = (rem != '0);
    out_data.digest_word = digest_buf[ridx];
    out_data.last_word = (rem == REM_W'(1));
    stat.req_type = item_type;
    stat.emit_busy = (rem != '0);
  end

endmodule

/* hdl/multilane_mix64_hash_top.sv */
// top level of the multilane mix64 message hash
//
// input channel in_valid / in_stall carries one word per handshake: a full
// 64-bit message word, a tail byte in the low 8 bits, or a finish request.
// a word is taken when in_valid is high and in_stall is low.
// each item runs one round on every lane; the lanes work in parallel, each
// with its own 32x32 multiplier. the two 64-bit constant multiplies of a
// round take three passes of that multiplier each, so an item holds the
// input through accept, prepare and the three multiply steps of each
// multiply; reserved request codes are taken and dropped without a round.
// a finish copies the lanes into a digest buffer and clears the hash state
// in the finish state after its round, once any previous digest is sent;
// output words then appear on out_valid / out_stall, highest lane first,
// last_word marking the final one. while the receiver stalls, the buffer
// holds and new message words are still accepted.
// cfg_valid / cfg_ready writes digest_mode; cfg_ready is always high.
// reset (rst, synchronous) clears lanes, byte count and tail state, empties
// the digest buffer and sets digest_mode to the 64-bit mode.
module multilane_mix64_hash_top #(
  parameter int MAX_LANES = mmh_pkg::MAX_LANES
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  mmh_pkg::mmh_in_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output mmh_pkg::mmh_out_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [mmh_pkg::MODE_W-1:0] cfg_data
);

  mmh_pkg::dp_cmd_t cmd;
  mmh_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  mmh_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_type(in_data.req_type),
    .stat(stat),
    .in_stall(in_stall),
    .cmd(cmd)
  );

  mmh_datapath #(
    .MAX_LANES(MAX_LANES)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .stat(stat),
    .in_data(in_data),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (in_data.req_type != mmh_pkg::REQ_RSV)) |=> in_stall)
    else $error("input taken again while a round is in progress");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.last_word) |=> !out_valid)
    else $error("digest words continue past the last word");

  a_rsv_no_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (in_data.req_type == mmh_pkg::REQ_RSV)) |=> !in_stall)
    else $error("reserved request started a round");

endmodule
